// ===== rtl/b64_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64_pkg
// shared types, codes and sizes for the lsb-first base64 codec
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int SYM_W       = 8;
    localparam int IDX_W       = 6;
    localparam int NUM_SYMS    = 64;
    localparam int GRP_SIZE    = 8;
    localparam int NUM_GRPS    = NUM_SYMS / GRP_SIZE;
    localparam int GRP_W       = 3;
    localparam int POS_W       = 3;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 8;
    localparam int WORD_SEL_W  = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    // request codes
    localparam logic [1:0] REQ_ENC_BYTE  = 2'd0;
    localparam logic [1:0] REQ_ENC_FLUSH = 2'd1;
    localparam logic [1:0] REQ_DEC_SYM   = 2'd2;
    localparam logic [1:0] REQ_RST_STATE = 2'd3;

    // position in the group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [SYM_W-1:0] data_in;
    } req_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_byte;
        logic             last;
    } rsp_item_t;

    // symbol i at bits [8i +: 8], word k covers symbols 8k..8k+7
    typedef logic [NUM_SYMS-1:0][SYM_W-1:0] alpha_t;
    typedef logic [NUM_GRPS-1:0][GRP_SIZE-1:0][SYM_W-1:0] alpha_grp_t;

    // classified request as it sits in the queue
    typedef struct packed {
        logic [1:0]                      req_type;
        logic [SYM_W-1:0]                data_in;
        logic [NUM_GRPS-1:0]             grp_hit;
        logic [NUM_GRPS-1:0][POS_W-1:0]  grp_pos;
    } q_item_t;

endpackage
`default_nettype wire

// ===== rtl/b64_alpha.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64_alpha
// alphabet register file, eight 64-bit words written over the config port
// ----------------------------------------------------------------------------
module b64_alpha (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [b64_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [b64_pkg::WORD_W-1:0]     cfg_data,
    output b64_pkg::alpha_t                     alpha
);
    import b64_pkg::*;

    logic [NUM_WORDS-1:0][WORD_W-1:0] words_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words_next;

    assign cfg_ready = 1'b1;
    assign alpha     = words_reg;

    always_comb
    begin
        words_next = words_reg;
        // indexes past the last word are dropped
        if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_WORDS)))
        begin
            words_next[cfg_index[WORD_SEL_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
        end
        else
        begin
            words_reg <= words_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64_front
// request intake, matches the incoming byte against every alphabet group
// ----------------------------------------------------------------------------
module b64_front (
    input  wire b64_pkg::alpha_t    alpha,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire b64_pkg::req_item_t req_data,
    input  wire logic               q_full,
    output logic                    push,
    output b64_pkg::q_item_t        push_item
);
    import b64_pkg::*;

    alpha_grp_t alpha_grp;

    assign alpha_grp = alpha;
    assign req_ready = !q_full;
    assign push      = req_valid && !q_full;

    // per group: any hit, and the lowest hitting position
    always_comb
    begin
        push_item.req_type = req_data.req_type;
        push_item.data_in  = req_data.data_in;
        push_item.grp_hit  = '0;
        push_item.grp_pos  = '0;
        for (int g = 0; g < NUM_GRPS; g++)
        begin
            for (int p = GRP_SIZE - 1; p >= 0; p--)
            begin
                if (alpha_grp[g][p] == req_data.data_in)
                begin
                    push_item.grp_hit[g] = 1'b1;
                    push_item.grp_pos[g] = POS_W'(p);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64_queue
// small fifo between the classifier and the executor
// ----------------------------------------------------------------------------
module b64_queue #(
    parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire b64_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output b64_pkg::q_item_t      head
);
    import b64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t            slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64_back
// executor: phase and carry update, symbol lookup, result register
// ----------------------------------------------------------------------------
module b64_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire b64_pkg::alpha_t  alpha,
    input  wire logic             head_valid,
    input  wire b64_pkg::q_item_t head,
    output logic                  pop,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output b64_pkg::rsp_item_t    rsp_data
);
    import b64_pkg::*;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [IDX_W-1:0] carry_reg;
    logic [IDX_W-1:0] carry_next;
    logic             second_reg;
    logic             second_next;
    logic [IDX_W-1:0] sec_idx_reg;
    logic [IDX_W-1:0] sec_idx_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_item_t        rsp_reg;
    rsp_item_t        rsp_next;

    logic             slot_free;
    logic [IDX_W-1:0] dec_idx;
    logic [9:0]       enc_v1;
    logic [11:0]      enc_v2;
    logic [13:0]      dec_v;
    logic             it_emit;
    logic             it_is_sym;
    logic             it_last;
    logic             it_second;
    logic [IDX_W-1:0] it_sidx;
    logic [IDX_W-1:0] it_sec_idx;
    logic [SYM_W-1:0] it_byte;
    logic [1:0]       it_phase;
    logic [IDX_W-1:0] it_carry;
    logic [IDX_W-1:0] look_idx;
    logic [SYM_W-1:0] look_sym;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign pop       = head_valid && !second_reg && slot_free;

    // first matching group, then its lowest position
    always_comb
    begin
        dec_idx = '0;
        for (int g = NUM_GRPS - 1; g >= 0; g--)
        begin
            if (head.grp_hit[g])
            begin
                dec_idx = {GRP_W'(g), head.grp_pos[g]};
            end
        end
    end

    always_comb
    begin
        enc_v1 = {4'b0, carry_reg} | {head.data_in, 2'b0};
        enc_v2 = {6'b0, carry_reg} | {head.data_in, 4'b0};
        unique case (phase_reg)
            PHASE_1: dec_v = {8'b0, carry_reg} | {2'b0, dec_idx, 6'b0};
            PHASE_2: dec_v = {8'b0, carry_reg} | {4'b0, dec_idx, 4'b0};
            PHASE_3: dec_v = {8'b0, carry_reg} | {6'b0, dec_idx, 2'b0};
            default: dec_v = {8'b0, carry_reg};
        endcase

        it_emit    = 1'b0;
        it_is_sym  = 1'b1;
        it_last    = 1'b1;
        it_second  = 1'b0;
        it_sidx    = carry_reg;
        it_sec_idx = enc_v2[11:6];
        it_byte    = dec_v[7:0];
        it_phase   = phase_reg;
        it_carry   = carry_reg;

        unique case (head.req_type)
            REQ_ENC_BYTE:
            begin
                it_emit = 1'b1;
                unique case (phase_reg)
                    PHASE_0:
                    begin
                        it_sidx  = head.data_in[IDX_W-1:0];
                        it_carry = {4'b0, head.data_in[7:6]};
                        it_phase = PHASE_1;
                    end
                    PHASE_1:
                    begin
                        it_sidx  = enc_v1[5:0];
                        it_carry = {2'b0, enc_v1[9:6]};
                        it_phase = PHASE_2;
                    end
                    PHASE_2:
                    begin
                        it_sidx   = enc_v2[5:0];
                        it_last   = 1'b0;
                        it_second = 1'b1;
                        it_carry  = '0;
                        it_phase  = PHASE_0;
                    end
                    default:
                    begin
                        // leftover carry goes out, carry kept
                        it_sidx  = carry_reg;
                        it_phase = PHASE_0;
                    end
                endcase
            end
            REQ_ENC_FLUSH:
            begin
                it_emit  = (phase_reg == PHASE_1) || (phase_reg == PHASE_2);
                it_phase = PHASE_0;
                it_carry = '0;
            end
            REQ_DEC_SYM:
            begin
                it_is_sym = 1'b0;
                it_phase  = phase_reg + 1'b1;
                if (phase_reg == PHASE_0)
                begin
                    it_carry = dec_idx;
                end
                else
                begin
                    it_emit  = 1'b1;
                    it_carry = dec_v[13:8];
                end
            end
            default:
            begin
                it_phase = PHASE_0;
                it_carry = '0;
            end
        endcase
    end

    // one alphabet read per cycle: the pending second symbol wins
    assign look_idx = second_reg ? sec_idx_reg : it_sidx;
    assign look_sym = alpha[look_idx];

    always_comb
    begin
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        second_next    = second_reg;
        sec_idx_next   = sec_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (second_reg)
        begin
            if (slot_free)
            begin
                rsp_valid_next    = 1'b1;
                rsp_next.out_byte = look_sym;
                rsp_next.last     = 1'b1;
                second_next       = 1'b0;
            end
        end
        else if (pop)
        begin
            phase_next     = it_phase;
            carry_next     = it_carry;
            second_next    = it_second;
            sec_idx_next   = it_sec_idx;
            rsp_valid_next = it_emit;
            if (it_emit)
            begin
                rsp_next.out_byte = it_is_sym ? look_sym : it_byte;
                rsp_next.last     = it_last;
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_0;
            carry_reg     <= '0;
            second_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            carry_reg     <= carry_next;
            second_reg    <= second_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_idx_reg <= sec_idx_next;
        rsp_reg     <= rsp_next;
    end

`ifndef NO_ASSERTIONS
    // a pending second symbol always sits behind a shown first one
    a_second_behind_first : assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> rsp_valid_reg)
        else $error("second symbol pending with empty result register");

    // nothing leaves the queue while the pair is unfinished
    a_no_pop_in_pair : assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !pop)
        else $error("queue popped while second symbol pending");

    // a third encoded byte always arms the second symbol
    a_pair_armed : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.req_type == REQ_ENC_BYTE && phase_reg == PHASE_2) |=> second_reg)
        else $error("third byte did not arm the second symbol");

    // only the first half of a pair goes out without last
    a_not_last_pair : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last) |-> second_reg)
        else $error("result without last outside a symbol pair");
`endif

endmodule
`default_nettype wire

// ===== rtl/base64_lsb_first_codec_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_lsb_first_codec_unit
// base64-style encoder and decoder with a programmable alphabet
// ----------------------------------------------------------------------------
// Each request word carries a request type and a byte. Encoding packs bits
// least significant first, three bytes to four symbols, with no padding; a
// flush sends the 2 or 4 leftover bits as one last symbol. Decoding maps a
// symbol to the index of its first alphabet match (0 when none match) and
// gives one byte for every symbol after the first of a group of four. Encode
// and decode share one phase and carry, and a reset request clears both.
// The 64-entry alphabet lives in eight 64-bit config registers, written over
// the cfg channel while the unit is idle; that binds the user, and the block
// itself does not enforce it. Internally a classifier compares the incoming
// byte with all alphabet entries at intake and pushes the per-group match
// summary into a two-deep queue; the executor behind it finishes the index
// search, updates phase and carry and loads a result register. The executor
// retires one request per cycle while the result channel does not stall it,
// except that the third byte of an encode group holds it while the second
// symbol goes out, because its two symbols share the single alphabet read
// port. Requests are taken while a result waits.
// ----------------------------------------------------------------------------
module base64_lsb_first_codec_unit #(
    parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire b64_pkg::req_item_t             req_data,
    // result channel
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output b64_pkg::rsp_item_t                  rsp_data,
    // config write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [b64_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [b64_pkg::WORD_W-1:0]     cfg_data
);
    import b64_pkg::*;

    alpha_t  alpha;
    logic    q_full;
    logic    push;
    q_item_t push_item;
    logic    pop;
    logic    head_valid;
    q_item_t head;

    // alphabet registers
    b64_alpha u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .alpha     (alpha)
    );

    // intake and symbol matching
    b64_front u_front (
        .alpha     (alpha),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decouples intake from execution
    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // phase/carry update and result register
    b64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .alpha      (alpha),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data)
    );

endmodule
`default_nettype wire
